// ===== rtl/core/bpc_pkg.sv =====
package bpc_pkg;

	localparam int TIME_BITS    = 16;
	localparam int CFG_W        = 16;
	localparam int CMP_W        = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
	localparam int BUTTON_COUNT = 3;
	localparam int CFG_IDX_W    = 2;

	localparam logic [TIME_BITS-1:0] TMAX = '1;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [CFG_W-1:0]     cfg_word_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SHORT  = 2'd1,
		EV_LONG   = 2'd2,
		EV_REPEAT = 2'd3
	} ev_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_SHORT    = 2'd1,
		REG_LONG     = 2'd2,
		REG_REPEAT   = 2'd3
	} reg_idx_t;

	localparam cfg_word_t DEBOUNCE_RST = 16'd50;
	localparam cfg_word_t SHORT_RST    = 16'd50;
	localparam cfg_word_t LONG_RST     = 16'd1000;
	localparam cfg_word_t REPEAT_RST   = 16'd200;

	typedef struct packed {
		cfg_word_t debounce_time;
		cfg_word_t short_min_time;
		cfg_word_t long_press_time;
		cfg_word_t repeat_period;
	} cfg_t;

	typedef struct packed {
		logic  raw_seen;
		logic  stable_level;
		time_t raw_age;
		time_t held_time;
		logic  long_done;
		logic  volume_hold;
		logic  first_step_sent;
		time_t repeat_left;
	} btn_state_t;

	function automatic time_t sat_inc(input time_t x);
		return (x == TMAX) ? x : x + 1'b1;
	endfunction

	function automatic logic time_ge(input time_t t, input cfg_word_t c);
		return CMP_W'(t) >= CMP_W'(c);
	endfunction

	function automatic time_t reload_value(input cfg_word_t period);
		return (CMP_W'(period) >= CMP_W'(TMAX)) ? TMAX : TIME_BITS'(period);
	endfunction

endpackage

// ===== rtl/core/bpc_button.sv =====
module bpc_button (
	input  logic                 level,
	input  logic                 vol_mode,
	input  logic                 vol_allowed,
	input  logic                 combo_now,
	input  logic                 combo_q,
	input  bpc_pkg::cfg_t        cfg,
	input  bpc_pkg::btn_state_t  st_cur,
	output bpc_pkg::btn_state_t  st_nxt,
	output bpc_pkg::ev_t         ev
);
	import bpc_pkg::*;

	btn_state_t s;
	ev_t        e;

	always_comb begin
		s = st_cur;
		e = EV_NONE;

		// age the timers first, saturating
		s.raw_age   = sat_inc(s.raw_age);
		s.held_time = sat_inc(s.held_time);
		if (s.repeat_left != '0) begin
			s.repeat_left = s.repeat_left - 1'b1;
		end

		if (combo_now) begin
			// hold: only the timers advance
		end else if (combo_q) begin
			// resync after the combo, mark handled
			s.raw_seen     = level;
			s.stable_level = level;
			s.raw_age      = '0;
			s.long_done    = 1'b1;
			s.volume_hold  = 1'b0;
		end else begin
			if (level != s.raw_seen) begin
				s.raw_seen = level;
				s.raw_age  = '0;
			end

			if (s.stable_level != s.raw_seen && time_ge(s.raw_age, cfg.debounce_time)) begin
				s.stable_level = s.raw_seen;
				if (s.stable_level) begin
					s.held_time       = '0;
					s.long_done       = 1'b0;
					s.volume_hold     = vol_allowed & vol_mode;
					s.first_step_sent = 1'b0;
					s.repeat_left     = '0;
				end else if (s.volume_hold) begin
					if (!s.first_step_sent && time_ge(s.held_time, cfg.short_min_time)) begin
						e = EV_SHORT;
					end
					s.volume_hold     = 1'b0;
					s.first_step_sent = 1'b0;
				end else if (!s.long_done) begin
					if (time_ge(s.held_time, cfg.short_min_time) &&
					    !time_ge(s.held_time, cfg.long_press_time)) begin
						e = EV_SHORT;
					end
				end
			end

			if (s.stable_level && s.volume_hold) begin
				if (!s.first_step_sent && time_ge(s.held_time, cfg.short_min_time)) begin
					s.first_step_sent = 1'b1;
					s.repeat_left     = reload_value(cfg.repeat_period);
					e                 = EV_SHORT;
				end else if (s.first_step_sent && s.repeat_left == '0) begin
					s.repeat_left = reload_value(cfg.repeat_period);
					e             = EV_REPEAT;
				end
			end else if (s.stable_level && !s.long_done &&
			             time_ge(s.held_time, cfg.long_press_time)) begin
				s.long_done = 1'b1;
				e           = EV_LONG;
			end
		end
	end

	assign st_nxt = s;
	assign ev     = e;

endmodule

// ===== rtl/core/button_press_classifier.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// input    | in_valid / in_stall  | play_level, up_level, down_level, in_volume_mode
// output   | out_valid / out_stall| play_event, up_event, down_event
// config   | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle sustained unless the output stalls; each goes into
// the input register, then through the button logic into the result register.
// Per-button state (debounce, hold timers, repeat countdown) loops through one register.
// arst_n clears the state to released buttons and loads the default timing registers.
// A stalled result holds the result register; the input register keeps taking a
// transaction as long as it can drain into a free or freeing result register.
module button_press_classifier (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             play_level,
	input  logic                             up_level,
	input  logic                             down_level,
	input  logic                             in_volume_mode,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       play_event,
	output logic [1:0]                       up_event,
	output logic [1:0]                       down_event,
	// configuration
	input  logic                             cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bpc_pkg::CFG_W-1:0]        cfg_data
);
	import bpc_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	// input stage
	logic                    valid_s1;
	logic [BUTTON_COUNT-1:0] level_s1;
	logic                    vol_s1;

	// result stage
	logic                    valid_s2;
	ev_t                     ev_s2 [BUTTON_COUNT];

	// per-button state and the combo flag
	btn_state_t              st_q   [BUTTON_COUNT];
	btn_state_t              st_nxt [BUTTON_COUNT];
	ev_t                     ev_nxt [BUTTON_COUNT];
	logic                    combo_q;

	logic                    advance;
	logic                    combo_now;

	// advance the input stage whenever the result register is free or being taken
	assign advance   = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	// up and down held together: freeze everything but the timers
	assign combo_now = level_s1[1] & level_s1[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= DEBOUNCE_RST;
			cfg_q.short_min_time  <= SHORT_RST;
			cfg_q.long_press_time <= LONG_RST;
			cfg_q.repeat_period   <= REPEAT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE: cfg_q.debounce_time   <= cfg_data;
				REG_SHORT:    cfg_q.short_min_time  <= cfg_data;
				REG_LONG:     cfg_q.long_press_time <= cfg_data;
				REG_REPEAT:   cfg_q.repeat_period   <= cfg_data;
				default:      ;
			endcase
		end
	end

	// capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			level_s1 <= {down_level, up_level, play_level};
			vol_s1   <= in_volume_mode;
		end
	end

	// per-button classification; play never enters volume hold
	for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_btn
		bpc_button u_button (
			.level       (level_s1[b]),
			.vol_mode    (vol_s1),
			.vol_allowed (b != 0),
			.combo_now   (combo_now),
			.combo_q     (combo_q),
			.cfg         (cfg_q),
			.st_cur      (st_q[b]),
			.st_nxt      (st_nxt[b]),
			.ev          (ev_nxt[b])
		);
	end

	// commit state only when the transaction moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BUTTON_COUNT; b++) begin
				st_q[b] <= '{raw_seen: 1'b0, stable_level: 1'b0, raw_age: '0,
				             held_time: '0, long_done: 1'b1, volume_hold: 1'b0,
				             first_step_sent: 1'b0, repeat_left: '0};
			end
			combo_q  <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				for (int b = 0; b < BUTTON_COUNT; b++) begin
					st_q[b] <= st_nxt[b];
				end
				combo_q <= combo_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			for (int b = 0; b < BUTTON_COUNT; b++) begin
				ev_s2[b] <= ev_nxt[b];
			end
		end
	end

	assign out_valid  = valid_s2;
	assign play_event = ev_s2[0];
	assign up_event   = ev_s2[1];
	assign down_event = ev_s2[2];

endmodule

// ===== rtl/core/bpc_checker.sv =====
module bpc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] play_event,
	input logic [1:0] up_event,
	input logic [1:0] down_event
);
	import bpc_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(play_event) && $stable(up_event) &&
		$stable(down_event))
		else $error("result changed while stalled");

	// the input only backs up when a result is stuck at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with a free result register");

	// play has no volume hold, so never repeats
	a_play_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> play_event != EV_REPEAT)
		else $error("repeat event on play");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.play_event (play_event),
	.up_event   (up_event),
	.down_event (down_event)
);
